// ===== rtl/assert_macros.svh =====
// assertion macros used by ntt_transform_engine_top
// each macro expands to nothing when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define NTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define NTT_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);
`else
`define NTT_ASSERT(lbl, prop, msg)
`define NTT_ASSERT_NEXT(lbl, trig, cons, msg)
`endif
`endif

// ===== rtl/ntt_pkg.sv =====
// constants, codes and twiddle tables for the ntt engine
// no dependencies
`default_nettype none
package ntt_pkg;

  localparam int COEFF_W = 30;
  localparam logic [COEFF_W-1:0] NTT_P = 30'd998244353;
  localparam logic [COEFF_W-1:0] NTT_G = 30'd3;
  localparam int MUL_STEPS = 30;
  localparam int ROOT_N = 23;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [3:0] LOG_RESET = 4'd10;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_INVERSE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOG_SIZE = 1'b1;

  typedef logic [COEFF_W-1:0] root_tbl_t [0:ROOT_N-1];
  typedef logic [COEFF_W-1:0] ninv_tbl_t [0:ROOT_N];

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // shift-and-add modular product, operands already reduced
  function automatic logic [COEFF_W-1:0] mul_const(logic [COEFF_W-1:0] a,
                                                   logic [COEFF_W-1:0] b);
    logic [COEFF_W:0] acc;
    acc = '0;
    for (int k = COEFF_W - 1; k >= 0; k--) begin
      acc = {acc[COEFF_W-1:0], 1'b0};
      if (acc >= {1'b0, NTT_P}) acc = acc - {1'b0, NTT_P};
      if (b[k]) acc = acc + {1'b0, a};
      if (acc >= {1'b0, NTT_P}) acc = acc - {1'b0, NTT_P};
    end
    return acc[COEFF_W-1:0];
  endfunction

  function automatic logic [COEFF_W-1:0] pow_const(logic [COEFF_W-1:0] b,
                                                   logic [COEFF_W-1:0] e);
    logic [COEFF_W-1:0] r;
    logic [COEFF_W-1:0] bb;
    r = 30'd1;
    bb = b;
    for (int k = 0; k < COEFF_W; k++) begin
      if (e[k]) r = mul_const(r, bb);
      bb = mul_const(bb, bb);
    end
    return r;
  endfunction

  // stage s has half-span 2^s, step root 3^((p-1)/2^(s+1)), inverted for the inverse table
  function automatic root_tbl_t make_roots(logic inv);
    root_tbl_t t;
    logic [COEFF_W-1:0] st;
    for (int s = 0; s < ROOT_N; s++) begin
      st = pow_const(NTT_G, (NTT_P - 30'd1) >> (s + 1));
      if (inv) st = pow_const(st, NTT_P - 30'd2);
      t[s] = st;
    end
    return t;
  endfunction

  function automatic ninv_tbl_t make_ninv();
    ninv_tbl_t t;
    for (int l = 0; l <= ROOT_N; l++) begin
      t[l] = pow_const(COEFF_W'(1) << l, NTT_P - 30'd2);
    end
    return t;
  endfunction

  localparam root_tbl_t ROOT_FWD = make_roots(1'b0);
  localparam root_tbl_t ROOT_INV = make_roots(1'b1);
  localparam ninv_tbl_t NINV = make_ninv();

endpackage
`default_nettype wire

// ===== rtl/ntt_if.sv =====
// valid/ready channel interfaces for request and response beats
// depends on ntt_pkg
`default_nettype none
interface ntt_req_if;
  import ntt_pkg::*;
  logic valid;
  logic ready;
  logic op;
  logic [COEFF_W-1:0] coeff_in;
  modport source(output valid, output op, output coeff_in, input ready);
  modport sink(input valid, input op, input coeff_in, output ready);
endinterface

interface ntt_rsp_if;
  import ntt_pkg::*;
  logic valid;
  logic ready;
  logic [COEFF_W-1:0] coeff_out;
  logic is_last;
  modport source(output valid, output coeff_out, output is_last, input ready);
  modport sink(input valid, input coeff_out, input is_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/ntt_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none
module ntt_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/ntt_mulmod.sv =====
// bit-serial modular multiplier mod 998244353, one bit of b per cycle
// depends on ntt_pkg; operands must already be reduced
`default_nettype none
module ntt_mulmod (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [ntt_pkg::COEFF_W-1:0] a,
  input  wire logic [ntt_pkg::COEFF_W-1:0] b,
  output ntt_pkg::mul_stat_t           stat,
  output logic [ntt_pkg::COEFF_W-1:0]  result
);
  import ntt_pkg::*;

  localparam int SW = $clog2(MUL_STEPS);

  logic [COEFF_W-1:0] acc, a_r, b_r;
  logic [SW-1:0] cnt;
  logic busy, done;
  logic [COEFF_W:0] dbl, sum;
  logic [COEFF_W-1:0] dbl_red, sum_red;

  // acc = 2*acc + bit*a, reduced after each add
  always_comb begin
    dbl = {acc, 1'b0};
    dbl_red = (dbl >= {1'b0, NTT_P}) ? COEFF_W'(dbl - {1'b0, NTT_P}) : COEFF_W'(dbl);
    sum = {1'b0, dbl_red} + (b_r[COEFF_W-1] ? {1'b0, a_r} : '0);
    sum_red = (sum >= {1'b0, NTT_P}) ? COEFF_W'(sum - {1'b0, NTT_P}) : COEFF_W'(sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= '0;
        a_r  <= a;
        b_r  <= b;
      end else if (busy) begin
        acc <= sum_red;
        b_r <= {b_r[COEFF_W-2:0], 1'b0};
        if (cnt == SW'(MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + SW'(1);
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result = acc;
endmodule
`default_nettype wire

// ===== rtl/ntt_transform_engine_top.sv =====
// radix-2 ntt engine mod 998244353: load, bit-reverse, butterflies, scaling, read-out
// Load beat: written to ram on acceptance. Read beat: state S_RD, then the result is
// registered onto rsp. No request is taken in S_RD; a waiting result holds the next read
// there, and so every request after it, loads too. The final load runs the transform
// (bit reversal, butterflies, inverse-only scaling); ready stays low until it ends.
// Butterflies and scaling share one bit-serial modular multiplier. Reset (synchronous)
// clears load/read counters, flags and sequencer; coefficient ram is not cleared.
`default_nettype none
`include "assert_macros.svh"
module ntt_transform_engine_top #(
  parameter int MAX_LOG_SIZE = 10
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  ntt_req_if.sink                           req,
  ntt_rsp_if.source                         rsp,
  input  wire logic                         cfg_we,
  input  wire logic [ntt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ntt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ntt_pkg::*;

  localparam int AW = MAX_LOG_SIZE;
  localparam int DEPTH = 1 << AW;
  localparam int LW = $clog2(MAX_LOG_SIZE + 1);
  localparam int CW = (LW > 4) ? LW : 4;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_BR   = 4'd2;
  localparam logic [3:0] S_BR1  = 4'd3;
  localparam logic [3:0] S_BR2  = 4'd4;
  localparam logic [3:0] S_BR3  = 4'd5;
  localparam logic [3:0] S_BF0  = 4'd6;
  localparam logic [3:0] S_BF1  = 4'd7;
  localparam logic [3:0] S_BF2  = 4'd8;
  localparam logic [3:0] S_BF3  = 4'd9;
  localparam logic [3:0] S_BF4  = 4'd10;
  localparam logic [3:0] S_BF5  = 4'd11;
  localparam logic [3:0] S_SC0  = 4'd12;
  localparam logic [3:0] S_SC1  = 4'd13;
  localparam logic [3:0] S_SC2  = 4'd14;

  logic [3:0] state;
  logic inv_cfg, inv_r;
  logic [3:0] log_cfg;
  logic [LW-1:0] lg, s_cnt, eff_log;
  logic [AW:0] load_count, ld_next, n_eff;
  logic [AW-1:0] read_count, i_cnt, c_cnt, jr_r, rd_addr;
  logic tdone, last_r;
  logic [COEFF_W-1:0] ua, vr, w_r;
  logic out_valid, out_last;
  logic [COEFF_W-1:0] out_data;

  logic [AW-1:0] nm1, cm1, rev_i, jr, h, kk, j_idx, jh_idx;
  logic ld_full, accept;
  logic [COEFF_W-1:0] step, ninv_v, in_red, add_res, sub_res;
  logic [COEFF_W:0] sum31;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [COEFF_W-1:0] ram_wdata, ram_rdata;

  logic mul_start;
  logic [COEFF_W-1:0] mul_a, mul_b, mres;
  mul_stat_t mstat;

  ntt_ram #(.WIDTH(COEFF_W), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  ntt_mulmod u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .stat(mstat), .result(mres)
  );

  assign req.ready = (state == S_IDLE);
  assign accept = req.valid && req.ready;
  assign rsp.valid = out_valid;
  assign rsp.coeff_out = out_data;
  assign rsp.is_last = out_last;

  always_comb begin
    eff_log = (CW'(log_cfg) > CW'(MAX_LOG_SIZE)) ? LW'(MAX_LOG_SIZE) : LW'(log_cfg);
    n_eff = (AW+1)'(1) << eff_log;
    ld_next = (tdone ? '0 : load_count) + (AW+1)'(1);
    ld_full = ld_next >= n_eff;
    nm1 = AW'(((AW+1)'(1) << lg) - (AW+1)'(1));
    cm1 = nm1 >> 1;
    for (int k = 0; k < AW; k++) rev_i[k] = i_cnt[AW-1-k];
    jr = rev_i >> (LW'(AW) - lg);
    h = AW'(1) << s_cnt;
    kk = c_cnt & (h - AW'(1));
    j_idx = ((c_cnt & ~(h - AW'(1))) << 1) | kk;
    jh_idx = j_idx | h;
    step = inv_r ? ROOT_INV[5'(s_cnt)] : ROOT_FWD[5'(s_cnt)];
    ninv_v = NINV[5'(lg)];
    in_red = (req.coeff_in >= NTT_P) ? req.coeff_in - NTT_P : req.coeff_in;
    sum31 = {1'b0, ua} + {1'b0, mres};
    add_res = (sum31 >= {1'b0, NTT_P}) ? COEFF_W'(sum31 - {1'b0, NTT_P}) : COEFF_W'(sum31);
    sub_res = (ua >= vr) ? ua - vr : COEFF_W'({1'b0, ua} + {1'b0, NTT_P} - {1'b0, vr});
  end

  // ram and multiplier port control
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    mul_start = 1'b0;
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_IDLE: begin
        if (accept && req.op == OP_LOAD) begin
          ram_we = 1'b1;
          ram_waddr = tdone ? '0 : load_count[AW-1:0];
          ram_wdata = in_red;
        end
        ram_raddr = read_count;
      end
      // keep the read data steady while the output beat waits
      S_RD:  ram_raddr = rd_addr;
      S_BR:  ram_raddr = i_cnt;
      S_BR1: ram_raddr = jr_r;
      S_BR2: begin
        ram_we = 1'b1;
        ram_waddr = i_cnt;
        ram_wdata = ram_rdata;
      end
      S_BR3: begin
        ram_we = 1'b1;
        ram_waddr = jr_r;
        ram_wdata = ua;
      end
      S_BF0: ram_raddr = j_idx;
      S_BF1: ram_raddr = jh_idx;
      S_BF2: begin
        mul_start = 1'b1;
        mul_a = ram_rdata;
        mul_b = w_r;
      end
      S_BF3: begin
        ram_we = mstat.done;
        ram_waddr = j_idx;
        ram_wdata = add_res;
      end
      S_BF4: begin
        ram_we = 1'b1;
        ram_waddr = jh_idx;
        ram_wdata = sub_res;
        mul_start = 1'b1;
        mul_a = w_r;
        mul_b = step;
      end
      S_SC0: ram_raddr = i_cnt;
      S_SC1: begin
        mul_start = 1'b1;
        mul_a = ram_rdata;
        mul_b = ninv_v;
      end
      S_SC2: begin
        ram_we = mstat.done;
        ram_waddr = i_cnt;
        ram_wdata = mres;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      inv_cfg <= 1'b0;
      log_cfg <= LOG_RESET;
      load_count <= '0;
      read_count <= '0;
      tdone <= 1'b0;
      out_valid <= 1'b0;
      lg <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INVERSE:  inv_cfg <= cfg_data[0];
          REG_LOG_SIZE: log_cfg <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_RD) out_valid <= 1'b1;
      else if (out_valid && rsp.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.op == OP_LOAD) begin
              if (tdone) begin
                tdone <= 1'b0;
                read_count <= '0;
              end
              if (ld_full) begin
                load_count <= '0;
                read_count <= '0;
                tdone <= 1'b0;
                lg <= eff_log;
                inv_r <= inv_cfg;
                i_cnt <= '0;
                state <= S_BR;
              end else begin
                load_count <= ld_next;
              end
            end else if (tdone) begin
              last_r <= (read_count == nm1);
              rd_addr <= read_count;
              state <= S_RD;
              if (read_count == nm1) begin
                tdone <= 1'b0;
                read_count <= '0;
              end else begin
                read_count <= read_count + AW'(1);
              end
            end
          end
        end
        S_RD: begin
          if (!out_valid || rsp.ready) begin
            out_data <= ram_rdata;
            out_last <= last_r;
            state <= S_IDLE;
          end
        end
        S_BR, S_BR3: begin
          if (state == S_BR) jr_r <= jr;
          if (state == S_BR && jr > i_cnt) begin
            state <= S_BR1;
          end else if (i_cnt == nm1) begin
            s_cnt <= '0;
            c_cnt <= '0;
            if (lg == '0) begin
              if (inv_r) begin
                i_cnt <= '0;
                state <= S_SC0;
              end else begin
                tdone <= 1'b1;
                state <= S_IDLE;
              end
            end else begin
              state <= S_BF0;
            end
          end else begin
            i_cnt <= i_cnt + AW'(1);
            state <= S_BR;
          end
        end
        S_BR1: begin
          ua <= ram_rdata;
          state <= S_BR2;
        end
        S_BR2: state <= S_BR3;
        S_BF0: begin
          if (kk == '0) w_r <= COEFF_W'(1);
          state <= S_BF1;
        end
        S_BF1: begin
          ua <= ram_rdata;
          state <= S_BF2;
        end
        S_BF2: state <= S_BF3;
        S_BF3: begin
          if (mstat.done) begin
            vr <= mres;
            state <= S_BF4;
          end
        end
        S_BF4: state <= S_BF5;
        S_BF5: begin
          if (mstat.done) begin
            w_r <= mres;
            if (c_cnt == cm1) begin
              c_cnt <= '0;
              if (s_cnt + LW'(1) == lg) begin
                if (inv_r) begin
                  i_cnt <= '0;
                  state <= S_SC0;
                end else begin
                  tdone <= 1'b1;
                  state <= S_IDLE;
                end
              end else begin
                s_cnt <= s_cnt + LW'(1);
                state <= S_BF0;
              end
            end else begin
              c_cnt <= c_cnt + AW'(1);
              state <= S_BF0;
            end
          end
        end
        S_SC0: state <= S_SC1;
        S_SC1: state <= S_SC2;
        S_SC2: begin
          if (mstat.done) begin
            if (i_cnt == nm1) begin
              tdone <= 1'b1;
              state <= S_IDLE;
            end else begin
              i_cnt <= i_cnt + AW'(1);
              state <= S_SC0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `NTT_ASSERT(a_busy_not_ready, (state != S_IDLE) |-> !req.ready, "ready high while busy")
  `NTT_ASSERT(a_mul_no_restart, mstat.busy |-> !mul_start, "multiplier restarted while busy")
  `NTT_ASSERT(a_out_from_read, $rose(out_valid) |-> ($past(state) == S_RD), "unexpected result beat")
  `NTT_ASSERT_NEXT(a_last_load_starts, accept && (req.op == OP_LOAD) && ld_full, state == S_BR, "transform did not start")
endmodule
`default_nettype wire

// ===== sim/ntt_scoreboard.sv =====
// checker for the ntt engine: watches request, response and config traffic,
// predicts each read-out coefficient and compares it; depends on ntt_pkg and ntt_if
`timescale 1ns / 100ps
module ntt_scoreboard (
  input  logic                       clk,
  input  logic                       rst,
  ntt_req_if                         req,
  ntt_rsp_if                         rsp,
  input  logic                       cfg_we,
  input  logic [ntt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ntt_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         pending
);
  import ntt_pkg::*;

  localparam int MAX_LG = 10;
  localparam int DEPTH = 1 << MAX_LG;
  localparam bit [63:0] PRIME = 64'(NTT_P);

  typedef bit [COEFF_W-1:0] residue_t;
  typedef struct {
    residue_t value;
    bit       last;
  } coeff_beat_t;

  residue_t    coeffs [0:DEPTH-1];
  coeff_beat_t expected_coeffs [$];
  int unsigned load_idx;
  int unsigned read_idx;
  int unsigned latched_lg;
  bit          results_ready;
  bit          inv_mode;
  bit [3:0]    log_len;

  function automatic residue_t mod_mul(residue_t a, residue_t b);
    bit [63:0] prod;
    prod = 64'(a) * 64'(b);
    return residue_t'(prod % PRIME);
  endfunction

  function automatic residue_t mod_pow(residue_t b, residue_t e);
    residue_t acc;
    acc = 1;
    while (e != 0) begin
      if (e[0]) acc = mod_mul(acc, b);
      b = mod_mul(b, b);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic void transform(int unsigned lg, bit inv);
    int unsigned n, i, j, k, h, rev;
    residue_t tmp, w, step, u, v, s;
    bit [63:0] wide;
    n = 1 << lg;
    for (i = 0; i < n; i++) begin
      rev = 0;
      for (k = 0; k < lg; k++) rev = (rev << 1) | ((i >> k) & 1);
      if (rev < i) begin
        tmp = coeffs[i];
        coeffs[i] = coeffs[rev];
        coeffs[rev] = tmp;
      end
    end
    for (h = 1; h < n; h = h << 1) begin
      step = mod_pow(residue_t'(3), residue_t'((PRIME - 1) / (2 * h)));
      if (inv) step = mod_pow(step, residue_t'(PRIME - 2));
      for (i = 0; i < n; i += 2 * h) begin
        w = 1;
        for (j = i; j < i + h; j++) begin
          u = coeffs[j];
          v = mod_mul(coeffs[j + h], w);
          wide = 64'(u) + 64'(v);
          coeffs[j] = (wide >= PRIME) ? residue_t'(wide - PRIME) : residue_t'(wide);
          coeffs[j + h] = (u >= v) ? residue_t'(u - v) : residue_t'(u + PRIME - v);
          w = mod_mul(w, step);
        end
      end
    end
    if (inv) begin
      s = mod_pow(residue_t'(n), residue_t'(PRIME - 2));
      for (i = 0; i < n; i++) coeffs[i] = mod_mul(coeffs[i], s);
    end
  endfunction

  function automatic void report(string what, longint exp_v, longint act_v);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
  endfunction

  always @(posedge clk) begin
    int unsigned lg, n;
    residue_t val;
    coeff_beat_t beat;
    if (rst) begin
      expected_coeffs.delete();
      load_idx = 0;
      read_idx = 0;
      latched_lg = 0;
      results_ready = 0;
      inv_mode = 0;
      log_len = LOG_RESET;
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_INVERSE) inv_mode = cfg_data[0];
        else if (cfg_index == REG_LOG_SIZE) log_len = cfg_data;
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_coeffs.size() == 0) begin
          report("unexpected beat, coeff_out", -1, rsp.coeff_out);
        end else begin
          beat = expected_coeffs.pop_front();
          if (rsp.coeff_out !== beat.value) report("coeff_out", beat.value, rsp.coeff_out);
          if (rsp.is_last !== beat.last) report("is_last", beat.last, rsp.is_last);
        end
      end
      if (req.valid && req.ready) begin
        if (req.op == OP_LOAD) begin
          lg = (log_len > MAX_LG) ? MAX_LG : log_len;
          n = 1 << lg;
          // a load over unread results starts a fresh block
          if (results_ready) begin
            results_ready = 0;
            read_idx = 0;
            load_idx = 0;
          end
          val = req.coeff_in;
          if (val >= PRIME) val = residue_t'(val - PRIME);
          coeffs[load_idx % DEPTH] = val;
          load_idx++;
          if (load_idx >= n) begin
            transform(lg, inv_mode);
            latched_lg = lg;
            results_ready = 1;
            load_idx = 0;
            read_idx = 0;
          end
        end else if (results_ready) begin
          beat.value = coeffs[read_idx % DEPTH];
          beat.last = (read_idx + 1) >= (1 << latched_lg);
          expected_coeffs.push_back(beat);
          read_idx++;
          if (beat.last) begin
            results_ready = 0;
            read_idx = 0;
          end
        end
      end
    end
    pending = expected_coeffs.size();
  end
endmodule

// ===== sim/tb_ntt_transform_engine_top.sv =====
// testbench top for ntt_transform_engine_top: clock, reset, load/read stimulus,
// config writes and verdict; depends on ntt_pkg, ntt_if and ntt_scoreboard
`timescale 1ns / 100ps
module tb_ntt_transform_engine_top;
  import ntt_pkg::*;

  localparam int STALL_LIMIT = 1500000;
  localparam int RANDOM_ITEMS = 1650;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int fail_count;
  int pending;
  int idle_cycles;
  int hold;
  int settle;
  int item_count;
  bit quiet;

  ntt_req_if req_ch();
  ntt_rsp_if rsp_ch();

  ntt_transform_engine_top u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  ntt_scoreboard u_scoreboard (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count),
    .pending(pending)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [COEFF_W-1:0] pick_coeff();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return NTT_P - 30'd1;
        2: return NTT_P;
        default: return '1;
      endcase
    end
    if (r < 15) return COEFF_W'($urandom);
    return COEFF_W'($urandom_range(0, NTT_P - 1));
  endfunction

  // bit reversal + butterflies + inverse scaling, with margin
  function automatic int xform_cycles(int lg);
    int n;
    n = 1 << lg;
    return 4 * n + 33 * n * lg + 34 * n + 200;
  endfunction

  // watchdog on beats moving
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("[ntt_transform_engine_top] ERROR");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold <= 0;
    end else if (hold > 0) begin
      hold <= hold - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) hold <= pick_gap();
    end
  end

  task automatic send(logic op, logic [COEFF_W-1:0] val);
    int g;
    g = pick_gap();
    if (g > 0 && !quiet) begin
      req_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op <= op;
    req_ch.coeff_in <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (op == OP_READ) settle = 0;
    item_count++;
  endtask

  // hold off until all read-outs are back and any transform has had time to end
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
    settle = 0;
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_block(int count, int lg);
    repeat (count) send(OP_LOAD, pick_coeff());
    settle = xform_cycles(lg);
  endtask

  task automatic run_block(int lg, bit inv);
    int n, k, reads;
    n = 1 << lg;
    if ($urandom_range(0, 99) < 15) repeat ($urandom_range(1, 2)) send(OP_READ, pick_coeff());
    cfg_write(REG_INVERSE, inv);
    if ($urandom_range(0, 9) == 0) begin
      // start under an oversized length, then shrink it mid-block
      cfg_write(REG_LOG_SIZE, $urandom_range(8, 15));
      k = $urandom_range(0, n + 1);
      repeat (k) send(OP_LOAD, pick_coeff());
      cfg_write(REG_LOG_SIZE, lg);
      k = (k >= n) ? 1 : n - k;
    end else begin
      cfg_write(REG_LOG_SIZE, lg);
      k = n;
    end
    load_block(k, lg);
    if ($urandom_range(0, 99) < 12) wait_idle();
    reads = ($urandom_range(0, 99) < 15) ? $urandom_range(0, n - 1) : n;
    if (reads == n && $urandom_range(0, 9) == 0) reads += $urandom_range(1, 2);
    repeat (reads) send(OP_READ, pick_coeff());
  endtask

  initial begin
    int r, lg;
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.op = OP_LOAD;
    req_ch.coeff_in = '0;
    rsp_ch.ready = 1'b0;
    settle = 0;
    item_count = 0;
    quiet = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // read with nothing transformed is dropped
    send(OP_READ, '0);
    // length one passes through, then length two with an unreduced input
    cfg_write(REG_LOG_SIZE, 0);
    cfg_write(REG_INVERSE, 0);
    load_block(1, 0);
    send(OP_READ, '0);
    send(OP_READ, '0);
    cfg_write(REG_INVERSE, 1);
    send(OP_LOAD, NTT_P - 30'd1);
    send(OP_READ, '0);
    cfg_write(REG_LOG_SIZE, 1);
    cfg_write(REG_INVERSE, 0);
    send(OP_LOAD, NTT_P - 30'd1);
    send(OP_LOAD, NTT_P);
    send(OP_READ, '0);
    send(OP_READ, '0);
    // partial read-out, then a load over the unread results
    cfg_write(REG_LOG_SIZE, 2);
    cfg_write(REG_INVERSE, 1);
    send(OP_LOAD, '0);
    send(OP_LOAD, NTT_P - 30'd1);
    send(OP_LOAD, 30'd1);
    send(OP_LOAD, 30'h2AAAAAAA);
    send(OP_READ, '0);
    send(OP_READ, '0);
    send(OP_LOAD, 30'h15555555);
    send(OP_LOAD, 30'd2);
    send(OP_LOAD, 30'd3);
    load_block(1, 2);
    repeat (4) send(OP_READ, '0);
    // oversized length, shrunk mid-block
    cfg_write(REG_LOG_SIZE, 15);
    repeat (3) send(OP_LOAD, pick_coeff());
    cfg_write(REG_LOG_SIZE, 1);
    load_block(1, 1);
    repeat (2) send(OP_READ, '0);

    // full length once, sender paused until the transform ends, head of it read back
    cfg_write(REG_INVERSE, 0);
    cfg_write(REG_LOG_SIZE, 10);
    load_block(1024, 10);
    wait_idle();
    repeat (128) send(OP_READ, pick_coeff());

    while (item_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) quiet = ~quiet;
      r = $urandom_range(0, 99);
      if (r < 80) lg = $urandom_range(0, 3);
      else if (r < 97) lg = $urandom_range(4, 6);
      else lg = 7;
      run_block(lg, $urandom_range(0, 1));
    end

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ntt_transform_engine_top] OK");
    end else begin
      $display("[ntt_transform_engine_top] ERROR");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ntt_pkg.sv
rtl/ntt_if.sv
rtl/ntt_ram.sv
rtl/ntt_mulmod.sv
rtl/ntt_transform_engine_top.sv
sim/ntt_scoreboard.sv
sim/tb_ntt_transform_engine_top.sv
